/* hw/rtl/particle_pool_euler_update_top_assert.svh */
// Assertion macros for the particle pool top level.
// Depends on nothing; included by particle_pool_euler_update_top.sv.
`ifndef PARTICLE_POOL_EULER_UPDATE_TOP_ASSERT_SVH
`define PARTICLE_POOL_EULER_UPDATE_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define PP_ASSERT_IMPL(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("pool check failed");

// Check that a condition implies a consequence in the next cycle.
`define PP_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("pool check failed");

`endif

/* hw/rtl/ppeu_pkg.sv */
// Shared types and constants for the particle pool block.
// Depends on nothing.
package ppeu_pkg;
    localparam int MAX_PARTICLES = 256;

    localparam logic [1:0] ACT_SPAWN = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic CFG_CAP  = 1'b0;
    localparam logic CFG_RATE = 1'b1;

    localparam logic [8:0]  CAP_RESET  = 9'd256;
    localparam logic [19:0] RATE_RESET = 20'd78643;

    // Datapath commands from the controller.
    typedef struct packed {
        logic spawn_wr;   // write input particle at count
        logic rd_issue;   // read slot at addr
        logic rd_last;    // read slot count-1
        logic copy_wr;    // write fetched particle to addr
        logic upd_wr;     // write updated particle to addr
        logic calc_f;     // compute decay factor
        logic mul_lo;     // phase-one products
        logic mul_hi;     // phase-two products
        logic cap_read;   // latch read result
        logic clr_read;   // clear read result
    } ppeu_cmd_t;

    typedef struct packed {
        logic dies;       // fetched life <= dt
    } ppeu_sts_t;
endpackage

/* hw/rtl/ppeu_datapath.sv */
// Particle storage and Euler update arithmetic for the particle pool.
// Depends on ppeu_pkg.
module ppeu_datapath #(
    parameter int AW = 8
) (
    input  logic                 clk,
    input  ppeu_pkg::ppeu_cmd_t  cmd,
    output ppeu_pkg::ppeu_sts_t  sts,
    input  logic [AW-1:0]        addr,
    input  logic [AW-1:0]        last_addr,
    input  logic [19:0]          damping_rate,
    input  logic [15:0]          dt,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic signed [31:0]   vel_x,
    input  logic signed [31:0]   vel_y,
    input  logic signed [31:0]   vel_z,
    input  logic [19:0]          life,
    output logic signed [31:0]   rd_pos_x,
    output logic signed [31:0]   rd_pos_y,
    output logic signed [31:0]   rd_pos_z,
    output logic [19:0]          rd_life
);
    localparam int DEPTH = 1 << AW;
    localparam int WW = 212;

    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] rdata_reg;
    logic [WW-1:0] wdata;
    logic [AW-1:0] waddr;
    logic          we;
    logic [16:0]   f_reg;
    logic [35:0]   d_prod;
    logic signed [31:0] p_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [63:0] disp_reg [3];
    logic signed [63:0] vnew_reg [3];
    logic signed [31:0] pn [3];
    logic signed [31:0] vn [3];
    logic signed [32:0] sum [3];
    logic [19:0]   l_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= mem[addr];
        end
        else if (cmd.rd_last)
        begin
            rdata_reg <= mem[last_addr];
        end
    end

    assign d_prod = 36'(damping_rate) * 36'(dt);

    always_ff @(posedge clk)
    begin
        if (cmd.calc_f)
        begin
            f_reg <= (d_prod[35:16] >= 20'd65536) ? 17'd0
                   : 17'(20'd65536 - d_prod[35:16]);
        end
    end

    assign sts.dies = (rdata_reg[19:0] <= 20'(dt));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = 33'(p_reg[k]) + 33'(disp_reg[k] >>> 16);
            if (sum[k][32] != sum[k][31])
            begin
                pn[k] = sum[k][32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
            else
            begin
                pn[k] = sum[k][31:0];
            end
            vn[k] = 32'(vnew_reg[k] >>> 16);
        end
    end

    // Phase one: displacement products; phase two: damping products.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (cmd.mul_lo)
            begin
                p_reg[k]    <= rdata_reg[20 + 32*k +: 32];
                v_reg[k]    <= rdata_reg[116 + 32*k +: 32];
                disp_reg[k] <= 64'(signed'(rdata_reg[116 + 32*k +: 32]))
                             * 64'(signed'({1'b0, dt}));
            end
            if (cmd.mul_hi)
            begin
                vnew_reg[k] <= 64'(v_reg[k]) * 64'(signed'({1'b0, f_reg}));
            end
        end
        if (cmd.mul_lo)
        begin
            l_reg <= rdata_reg[19:0] - 20'(dt);
        end
    end

    always_comb
    begin
        we = 1'b0;
        waddr = addr;
        wdata = rdata_reg;
        if (cmd.spawn_wr)
        begin
            we = 1'b1;
            wdata = {vel_z, vel_y, vel_x, pos_z, pos_y, pos_x, life};
        end
        else if (cmd.copy_wr)
        begin
            we = 1'b1;
        end
        else if (cmd.upd_wr)
        begin
            we = 1'b1;
            wdata = {vn[2], vn[1], vn[0], pn[2], pn[1], pn[0], l_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_read)
        begin
            rd_life  <= rdata_reg[19:0];
            rd_pos_x <= rdata_reg[51:20];
            rd_pos_y <= rdata_reg[83:52];
            rd_pos_z <= rdata_reg[115:84];
        end
        else if (cmd.clr_read)
        begin
            rd_life  <= '0;
            rd_pos_x <= '0;
            rd_pos_y <= '0;
            rd_pos_z <= '0;
        end
    end
endmodule

/* hw/rtl/ppeu_ctrl.sv */
// Sequencer for spawn, tick and read items of the particle pool.
// Depends on ppeu_pkg.
module ppeu_ctrl #(
    parameter int AW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          action,
    input  logic [AW-1:0]       index,
    input  logic [8:0]          capacity_limit,
    input  ppeu_pkg::ppeu_sts_t sts,
    output ppeu_pkg::ppeu_cmd_t cmd,
    output logic [AW-1:0]       addr,
    output logic [AW-1:0]       last_addr,
    output logic                busy,
    output logic                done,
    output logic [AW:0]         count,
    output logic                accepted,
    output logic                valid_res
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_FETCH = 9'b000000100,
        S_EVAL  = 9'b000001000,
        S_LAST  = 9'b000010000,
        S_COPY  = 9'b000100000,
        S_MUL2  = 9'b001000000,
        S_WRITE = 9'b010000000,
        S_READ  = 9'b100000000
    } state_t;

    localparam int DEPTH = 1 << AW;

    state_t          state_reg, state_next;
    logic [AW:0]     count_reg, count_next;
    logic [AW:0]     i_reg, i_next;
    logic [AW-1:0]   ridx_reg, ridx_next;
    logic            acc_reg, acc_next, vld_reg, vld_next, done_next, done_reg;
    logic [AW:0]     cap;

    assign cap = (capacity_limit > 9'(DEPTH)) ? (AW+1)'(DEPTH) : (AW+1)'(capacity_limit);
    assign count = count_reg;
    assign accepted = acc_reg;
    assign valid_res = vld_reg;
    assign done = done_reg;
    assign busy = (state_reg != S_IDLE);
    assign last_addr = AW'(count_reg - 1'b1);
    assign addr = (state_reg == S_READ) ? ridx_reg
                : (state_reg == S_IDLE) ? count_reg[AW-1:0] : i_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next = i_reg;
        ridx_next = ridx_reg;
        acc_next = acc_reg;
        vld_next = vld_reg;
        done_next = 1'b0;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    acc_next = 1'b0;
                    vld_next = 1'b0;
                    i_next = '0;
                    ridx_next = index;
                    cmd.clr_read = 1'b1;
                    if (action == ppeu_pkg::ACT_SPAWN)
                    begin
                        if (count_reg < cap)
                        begin
                            // store the beat at slot count while its fields are valid
                            cmd.spawn_wr = 1'b1;
                            state_next = S_WRITE;
                            acc_next = 1'b1;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    else if (action == ppeu_pkg::ACT_TICK)
                    begin
                        cmd.calc_f = 1'b1;
                        state_next = S_CHECK;
                    end
                    else if (action == ppeu_pkg::ACT_READ
                             && (AW+1)'(index) < count_reg)
                    begin
                        vld_next = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                if (i_reg < count_reg)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next = 1'b1;
                end
            end
            S_FETCH:
            begin
                cmd.rd_issue = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.dies)
                begin
                    count_next = count_reg - 1'b1;
                    if (AW'(count_reg - 1'b1) != i_reg[AW-1:0])
                    begin
                        cmd.rd_last = 1'b1;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    cmd.mul_lo = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_COPY:
            begin
                // moved particle sits in the read register: write and re-check it
                cmd.copy_wr = 1'b1;
                state_next = S_EVAL;
            end
            S_MUL2:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_LAST;
            end
            S_LAST:
            begin
                cmd.upd_wr = 1'b1;
                i_next = i_reg + 1'b1;
                state_next = S_CHECK;
            end
            S_WRITE:
            begin
                count_next = count_reg + 1'b1;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next = S_FETCH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_FETCH)
        begin
            // read path reuses the fetch state: latch result and finish
            cmd.rd_issue = 1'b0;
            cmd.cap_read = 1'b1;
            state_next = S_IDLE;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            i_reg <= '0;
            ridx_reg <= '0;
            acc_reg <= 1'b0;
            vld_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg <= i_next;
            ridx_reg <= ridx_next;
            acc_reg <= acc_next;
            vld_reg <= vld_next;
            done_reg <= done_next;
        end
    end
endmodule

/* hw/rtl/particle_pool_euler_update_top.sv */
// Particle pool with explicit Euler update. A tick walks the live slots:
// a surviving particle goes through two multiply phases and a write-back;
// a dying one is dropped, and the last live particle, if another, is moved
// into its slot and checked. A new item is taken in the done cycle; rst_n
// clears count, controller state and config registers, not the pool memory
// or the datapath registers. The receiver cannot stall: done pulses once.
`include "particle_pool_euler_update_top_assert.svh"
module particle_pool_euler_update_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [1:0]         action,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [19:0]        life,
    input  logic [15:0]        dt,
    input  logic [7:0]         index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [19:0]        cfg_data,
    output logic [8:0]         live_count,
    output logic               accepted,
    output logic               valid_res,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic [19:0]        out_life
);
    localparam int AW = $clog2(ppeu_pkg::MAX_PARTICLES);

    ppeu_pkg::ppeu_cmd_t cmd;
    ppeu_pkg::ppeu_sts_t sts;
    logic [AW-1:0] addr, last_addr;
    logic [AW:0]   count;
    logic [8:0]    cap_reg;
    logic [19:0]   rate_reg;
    logic [15:0]   dt_reg;

    // Config beats always taken; only send them while idle, not enforced.
    assign cfg_ready = 1'b1;
    assign live_count = 9'(count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= ppeu_pkg::CAP_RESET;
            rate_reg <= ppeu_pkg::RATE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ppeu_pkg::CFG_CAP)
            begin
                cap_reg <= cfg_data[8:0];
            end
            else
            begin
                rate_reg <= cfg_data;
            end
        end
    end

    // Hold the tick step for the whole walk.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            dt_reg <= dt;
        end
    end

    ppeu_ctrl #(.AW(AW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action),
        .index(index), .capacity_limit(cap_reg), .sts(sts), .cmd(cmd),
        .addr(addr), .last_addr(last_addr), .busy(busy), .done(done),
        .count(count), .accepted(accepted), .valid_res(valid_res)
    );

    ppeu_datapath #(.AW(AW)) u_dp (
        .clk(clk), .cmd(cmd), .sts(sts), .addr(addr), .last_addr(last_addr),
        .damping_rate(rate_reg), .dt(cmd.calc_f ? dt : dt_reg),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .life(life),
        .rd_pos_x(out_pos_x), .rd_pos_y(out_pos_y), .rd_pos_z(out_pos_z),
        .rd_life(out_life)
    );

    `PP_ASSERT_IMPL(a_count_range, 1'b1, count <= 9'(ppeu_pkg::MAX_PARTICLES))
    `PP_ASSERT_IMPL(a_flags_excl, done, !(accepted && valid_res))
    `PP_ASSERT_IMPL(a_done_idle, done, !busy)
    `PP_ASSERT_NEXT(a_start_moves, start && !busy, busy || done)
endmodule

/* test/particle_pool_euler_update_top_test.sv */
// Testbench for the particle pool block: spawn, tick and read beats are
// checked against a fixed-point predictor that keeps its own copy of the pool.
// Depends on ppeu_pkg and particle_pool_euler_update_top.
module particle_pool_euler_update_top_test;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int POOL_DEPTH = 256;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]         act;
        logic signed [31:0] px, py, pz;
        logic signed [31:0] vx, vy, vz;
        logic [19:0]        life;
        logic [15:0]        dt;
        logic [7:0]         idx;
    } pool_cmd_t;

    typedef struct {
        logic [8:0]         count;
        logic               acc;
        logic               hit;
        logic signed [31:0] x, y, z;
        logic [19:0]        life;
    } pool_reply_t;

    // Scoreboard: holds the predicted pool and the replies it still owes.
    class pool_scoreboard;
        logic signed [31:0] pos [POOL_DEPTH][3];
        logic signed [31:0] vel [POOL_DEPTH][3];
        logic [19:0]        rem [POOL_DEPTH];
        int unsigned        live;
        logic [8:0]         cap_reg;
        logic [19:0]        rate_reg;
        pool_reply_t        owed[$];
        int                 errors;

        function new();
            live = 0;
            cap_reg = ppeu_pkg::CAP_RESET;
            rate_reg = ppeu_pkg::RATE_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [19:0] data);
            if (idx == ppeu_pkg::CFG_CAP) cap_reg = data[8:0];
            else rate_reg = data;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        // One Euler step on every live particle, compacting dead ones away.
        function void advance_pool(logic [15:0] dt);
            longint d, f, disp, sum;
            int unsigned i, last;
            d = (longint'(rate_reg) * longint'(dt)) >> 16;
            f = (d >= 65536) ? 0 : 65536 - d;
            i = 0;
            while (i < live) begin
                if (rem[i] <= dt) begin
                    last = live - 1;
                    pos[i] = pos[last];
                    vel[i] = vel[last];
                    rem[i] = rem[last];
                    live = last;
                end
                else begin
                    rem[i] = rem[i] - dt;
                    for (int a = 0; a < 3; a++) begin
                        disp = (longint'(vel[i][a]) * longint'(dt)) >>> 16;
                        sum = longint'(pos[i][a]) + disp;
                        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                        pos[i][a] = sum[31:0];
                        sum = (longint'(vel[i][a]) * f) >>> 16;
                        vel[i][a] = sum[31:0];
                    end
                    i++;
                end
            end
        endfunction

        // Note an accepted beat and queue the reply it must produce.
        function void note_cmd(pool_cmd_t c);
            pool_reply_t r;
            int unsigned lim;
            r = '{default: 0};
            lim = (cap_reg > POOL_DEPTH) ? POOL_DEPTH : cap_reg;
            case (c.act)
                ppeu_pkg::ACT_SPAWN: if (live < lim) begin
                    pos[live] = '{c.px, c.py, c.pz};
                    vel[live] = '{c.vx, c.vy, c.vz};
                    rem[live] = c.life;
                    live++;
                    r.acc = 1'b1;
                end
                ppeu_pkg::ACT_TICK: advance_pool(c.dt);
                ppeu_pkg::ACT_READ: if (c.idx < live) begin
                    r.hit = 1'b1;
                    r.x = pos[c.idx][0];
                    r.y = pos[c.idx][1];
                    r.z = pos[c.idx][2];
                    r.life = rem[c.idx];
                end
                default: ;
            endcase
            r.count = live[8:0];
            owed = {owed, r};
        endfunction

        task check_reply(pool_reply_t got);
            pool_reply_t e;
            if (owed.size() == 0) begin
                report("reply with nothing outstanding");
                return;
            end
            e = owed.pop_front();
            if (got.count !== e.count)
                report($sformatf("live_count %0d, want %0d", got.count, e.count));
            if (got.acc !== e.acc)
                report($sformatf("accepted %0b, want %0b", got.acc, e.acc));
            if (got.hit !== e.hit)
                report($sformatf("valid_res %0b, want %0b", got.hit, e.hit));
            if (got.x !== e.x) report($sformatf("out_pos_x %h, want %h", got.x, e.x));
            if (got.y !== e.y) report($sformatf("out_pos_y %h, want %h", got.y, e.y));
            if (got.z !== e.z) report($sformatf("out_pos_z %h, want %h", got.z, e.z));
            if (got.life !== e.life)
                report($sformatf("out_life %h, want %h", got.life, e.life));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    logic [1:0]         action;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic [19:0]        life;
    logic [15:0]        dt;
    logic [7:0]         index;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [19:0]        cfg_data;
    logic [8:0]         live_count;
    logic               accepted;
    logic               valid_res;
    logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
    logic [19:0]        out_life;

    pool_scoreboard sb;
    int  idle_cycles;
    int  burst_left;
    bit  gaps_on;

    particle_pool_euler_update_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .action(action), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .life(life), .dt(dt),
        .index(index), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .live_count(live_count),
        .accepted(accepted), .valid_res(valid_res), .out_pos_x(out_pos_x),
        .out_pos_y(out_pos_y), .out_pos_z(out_pos_z), .out_life(out_life)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side: done is a one-cycle strobe, so check every pulse as it ends.
    always @(posedge clk)
    begin
        pool_reply_t got;
        if (rst_n && done) begin
            got = '{live_count, accepted, valid_res, out_pos_x, out_pos_y,
                    out_pos_z, out_life};
            sb.check_reply(got);
        end
    end

    // Watchdog: any beat on any channel resets the idle count.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Drive one command beat and hold it until the block takes it.
    // Start stays high across back-to-back beats; drop it only for a gap.
    task automatic send_cmd(pool_cmd_t c);
        int gap;
        start  <= 1'b1;
        action <= c.act;
        pos_x  <= c.px;
        pos_y  <= c.py;
        pos_z  <= c.pz;
        vel_x  <= c.vx;
        vel_y  <= c.vy;
        vel_z  <= c.vz;
        life   <= c.life;
        dt     <= c.dt;
        index  <= c.idx;
        do @(posedge clk); while (busy);
        sb.note_cmd(c);
        if (burst_left > 0)
            burst_left--;
        else begin
            burst_left = $urandom_range(0, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 7);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Let all outstanding replies drain before touching a register.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    function automatic pool_cmd_t make_cmd(logic [1:0] act, logic signed [31:0] p,
                                           logic signed [31:0] v, logic [19:0] lf,
                                           logic [15:0] step, logic [7:0] idx);
        pool_cmd_t c;
        c = '{act, p, -p, p ^ 32'h5a5a_0000, v, ~v, v >>> 3, lf, step, idx};
        return c;
    endfunction

    // Random beat: mostly spawns and reads of live slots, with ticks to age
    // the pool and a little noise (unused action, out-of-range reads).
    function automatic pool_cmd_t random_cmd();
        pool_cmd_t c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        c.px = $urandom;
        c.py = $urandom;
        c.pz = $urandom;
        c.vx = $urandom;
        c.vy = $urandom;
        c.vz = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            c.vx = c.vx >>> $urandom_range(8, 20);
            c.vy = c.vy >>> $urandom_range(8, 20);
            c.vz = c.vz >>> $urandom_range(8, 20);
        end
        c.life = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 200000));
        c.dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12000));
        c.idx = (sb.live > 0 && $urandom_range(0, 9) != 0)
                ? 8'($urandom_range(0, sb.live - 1)) : 8'($urandom);
        if (pick < 45)      c.act = ppeu_pkg::ACT_SPAWN;
        else if (pick < 58) c.act = ppeu_pkg::ACT_TICK;
        else if (pick < 95) c.act = ppeu_pkg::ACT_READ;
        else                c.act = ACT_UNUSED;
        return c;
    endfunction

    initial
    begin
        logic [8:0]  caps [6];
        logic [19:0] rates [6];
        sb = new();
        idle_cycles = 0;
        burst_left = 0;
        gaps_on = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        action = ppeu_pkg::ACT_SPAWN;
        {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z} = '0;
        life = '0;
        dt = '0;
        index = '0;
        cfg_valid = 1'b0;
        cfg_index = ppeu_pkg::CFG_CAP;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a two-slot pool with extreme particles, a full-pool spawn,
        // a zero-life particle, out-of-range and unused-action beats.
        write_reg(ppeu_pkg::CFG_CAP, 20'd2);
        send_cmd(make_cmd(ppeu_pkg::ACT_READ, 0, 0, 0, 0, 8'd0));
        send_cmd(make_cmd(ppeu_pkg::ACT_SPAWN, 32'sh7fff_ffff, 32'sh7fff_ffff,
                          20'hfffff, 0, 0));
        send_cmd(make_cmd(ppeu_pkg::ACT_SPAWN, 32'sh8000_0000, 32'sh8000_0000,
                          20'd0, 0, 0));
        send_cmd(make_cmd(ppeu_pkg::ACT_SPAWN, 32'sd1, 32'sd1, 20'd5, 0, 0));
        send_cmd(make_cmd(ppeu_pkg::ACT_READ, 0, 0, 0, 0, 8'd0));
        send_cmd(make_cmd(ppeu_pkg::ACT_READ, 0, 0, 0, 0, 8'd1));
        send_cmd(make_cmd(ppeu_pkg::ACT_READ, 0, 0, 0, 0, 8'd255));
        send_cmd(make_cmd(ACT_UNUSED, 32'sh7fff_ffff, 0, 20'hfffff, 16'hffff, 8'hff));
        send_cmd(make_cmd(ppeu_pkg::ACT_TICK, 0, 0, 0, 16'd0, 0));
        send_cmd(make_cmd(ppeu_pkg::ACT_READ, 0, 0, 0, 0, 8'd0));
        send_cmd(make_cmd(ppeu_pkg::ACT_TICK, 0, 0, 0, 16'hffff, 0));
        send_cmd(make_cmd(ppeu_pkg::ACT_READ, 0, 0, 0, 0, 8'd0));
        write_reg(ppeu_pkg::CFG_RATE, 20'hfffff);
        send_cmd(make_cmd(ppeu_pkg::ACT_SPAWN, 32'sh8000_0000, 32'sh8000_0000,
                          20'hfffff, 0, 0));
        send_cmd(make_cmd(ppeu_pkg::ACT_TICK, 0, 0, 0, 16'hffff, 0));
        send_cmd(make_cmd(ppeu_pkg::ACT_READ, 0, 0, 0, 0, 8'd1));
        send_cmd(make_cmd(ppeu_pkg::ACT_TICK, 0, 0, 0, 16'd1, 0));
        send_cmd(make_cmd(ppeu_pkg::ACT_READ, 0, 0, 0, 0, 8'd0));
        write_reg(ppeu_pkg::CFG_CAP, 20'd0);
        send_cmd(make_cmd(ppeu_pkg::ACT_TICK, 0, 0, 0, 16'hffff, 0));
        send_cmd(make_cmd(ppeu_pkg::ACT_TICK, 0, 0, 0, 16'hffff, 0));
        send_cmd(make_cmd(ppeu_pkg::ACT_SPAWN, 32'sd7, 32'sd7, 20'd7, 0, 0));

        // Random phases, each under its own register setting.
        caps  = '{9'd511, 9'd1, 9'd256, 9'd17, 9'd255, 9'd64};
        rates = '{20'd0, 20'd78643, 20'hfffff, 20'd3000, 20'd400000, 20'd78643};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ppeu_pkg::CFG_CAP, {11'd0, caps[ph]});
            write_reg(ppeu_pkg::CFG_RATE, (ph == 3) ? 20'($urandom) : rates[ph]);
            gaps_on = (ph % 3) != 2;
            repeat (330) send_cmd(random_cmd());
        end

        // Let the tail drain, then idle before the final verdict.
        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ppeu_pkg.sv
hw/rtl/ppeu_datapath.sv
hw/rtl/ppeu_ctrl.sv
hw/rtl/particle_pool_euler_update_top.sv
test/particle_pool_euler_update_top_test.sv
